[hdl/lanc_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, widths and control types of the LMS noise canceller.
// No dependencies; every other file but lanc_ram imports this package.
package lanc_pkg;

  localparam int TAPS   = 128;
  localparam int AW     = $clog2(TAPS);
  localparam int CW     = $clog2(TAPS + 2);

  localparam int SMP_W  = 16;
  localparam int WGT_W  = 32;
  localparam int STEP_W = 16;
  localparam logic [STEP_W-1:0] STEP_RESET = 16'd655;

  localparam int SMP_MAX = 32767;
  localparam int SMP_MIN = -32768;

  // mu * error fits in 33 signed bits; one multiplier of MUE_W x SMP_W serves all
  localparam int MUE_W  = STEP_W + SMP_W + 1;
  localparam int PROD_W = MUE_W + SMP_W;
  localparam int ACC_W  = WGT_W + SMP_W + AW;

  localparam int EST_SHIFT = 28;
  localparam int UPD_SHIFT = 18;

  typedef enum logic [1:0] {
    MUL_FIR,
    MUL_STEP,
    MUL_UPD
  } mul_sel_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    logic     d_load;
    logic     acc_clr;
    logic     acc_en;
    logic     est_en;
    logic     mue_en;
    logic     wupd_en;
    logic     wclr_en;
  } ctl_t;

endpackage

[hdl/lanc_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for sample beats in and error beats out.
// Depends on lanc_pkg for the sample width.
interface lanc_in_if;
  import lanc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] reference_sample;
  logic signed [SMP_W-1:0] desired_sample;
  modport source (output valid, output reference_sample, output desired_sample, input ready);
  modport sink (input valid, input reference_sample, input desired_sample, output ready);
endinterface

interface lanc_out_if;
  import lanc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] error_sample;
  modport source (output valid, output error_sample, input ready);
  modport sink (input valid, input error_sample, output ready);
endinterface

[hdl/lanc_ram.sv]
`timescale 1ns / 1ps
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module lanc_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/lanc_dp.sv]
`timescale 1ns / 1ps
// Datapath: the shared multiplier, the FIR accumulator, error rounding and
// saturation, and the saturating weight update. Depends on lanc_pkg.
module lanc_dp (
  input  logic                              clk,
  input  lanc_pkg::ctl_t                    ctl,
  input  logic [lanc_pkg::STEP_W-1:0]       step_size,
  input  logic signed [lanc_pkg::SMP_W-1:0] desired_sample,
  input  logic signed [lanc_pkg::SMP_W-1:0] hist_q,
  input  logic signed [lanc_pkg::WGT_W-1:0] w_q,
  output logic signed [lanc_pkg::SMP_W-1:0] error_sample,
  output logic signed [lanc_pkg::WGT_W-1:0] w_wdata
);
  import lanc_pkg::*;

  localparam int EST_W = ACC_W - EST_SHIFT;
  localparam int EW    = EST_W + 1;
  localparam int INC_W = PROD_W - UPD_SHIFT;
  localparam int NW_W  = WGT_W + 1;
  localparam logic signed [EW-1:0] E_MAX = EW'(SMP_MAX);
  localparam logic signed [EW-1:0] E_MIN = EW'(SMP_MIN);

  logic signed [MUE_W-1:0]  mul_a;
  logic signed [SMP_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [EST_W-1:0]  est;
  logic signed [EW-1:0]     err;
  logic signed [SMP_W-1:0]  e_sat;
  logic signed [SMP_W-1:0]  d_r;
  logic signed [SMP_W-1:0]  e_r;
  logic signed [MUE_W-1:0]  mue_r;
  logic signed [WGT_W-1:0]  w_d_r;
  logic signed [PROD_W-1:0] upd_rnd;
  logic signed [INC_W-1:0]  inc;
  logic signed [NW_W-1:0]   nw;
  logic signed [WGT_W-1:0]  w_sat;

  always_comb begin
    case (ctl.mul_sel)
      MUL_FIR: begin
        mul_a = MUE_W'(w_q);
        mul_b = hist_q;
      end
      MUL_STEP: begin
        mul_a = MUE_W'(step_size);
        mul_b = e_r;
      end
      MUL_UPD: begin
        mul_a = mue_r;
        mul_b = hist_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    if (ctl.acc_clr) begin
      acc_nxt = '0;
    end else if (ctl.acc_en) begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end else begin
      acc_nxt = acc_r;
    end
  end

  // round half up, then floor to Q1.15
  assign acc_rnd = acc_r + (ACC_W'(1) << (EST_SHIFT - 1));
  assign est     = acc_rnd[ACC_W-1:EST_SHIFT];
  assign err     = EW'(d_r) - EW'(est);

  always_comb begin
    if (err > E_MAX) begin
      e_sat = SMP_W'(SMP_MAX);
    end else if (err < E_MIN) begin
      e_sat = SMP_W'(SMP_MIN);
    end else begin
      e_sat = err[SMP_W-1:0];
    end
  end

  assign upd_rnd = prod_r + (PROD_W'(1) << (UPD_SHIFT - 1));
  assign inc     = upd_rnd[PROD_W-1:UPD_SHIFT];
  assign nw      = NW_W'(w_d_r) + NW_W'(inc);

  always_comb begin
    if (nw[NW_W-1] != nw[NW_W-2]) begin
      w_sat = nw[NW_W-1] ? {1'b1, {(WGT_W-1){1'b0}}} : {1'b0, {(WGT_W-1){1'b1}}};
    end else begin
      w_sat = nw[WGT_W-1:0];
    end
  end

  assign w_wdata      = ctl.wclr_en ? '0 : w_sat;
  assign error_sample = e_r;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    w_d_r  <= w_q;
    acc_r  <= acc_nxt;
    if (ctl.d_load) begin
      d_r <= desired_sample;
    end
    if (ctl.est_en) begin
      e_r <= e_sat;
    end
    if (ctl.mue_en) begin
      mue_r <= prod_r[MUE_W-1:0];
    end
  end

endmodule

[hdl/lanc_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer: weight clear sweep, warm-up count, tap walks for the filter
// and the update passes, delay-line pointers and the output beat flag.
// Depends on lanc_pkg.
module lanc_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    out_ready,
  output logic                    in_ready,
  output logic                    out_valid,
  output lanc_pkg::ctl_t          ctl,
  output logic                    hist_we,
  output logic [lanc_pkg::AW-1:0] hist_waddr,
  output logic [lanc_pkg::AW-1:0] hist_raddr,
  output logic [lanc_pkg::AW-1:0] w_raddr,
  output logic [lanc_pkg::AW-1:0] w_waddr
);
  import lanc_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIR,
    ST_EST,
    ST_MU,
    ST_MUE,
    ST_UPD
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] warm_r, warm_nxt;
  logic [AW-1:0] a1_r, a2_r;
  logic          v1_r, v2_r;
  logic          out_valid_r, out_valid_nxt;
  logic          accept;
  logic          issue;
  logic [AW-1:0] wp_inc;

  assign in_ready   = (state_r == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign wp_inc     = (wp_r == AW'(TAPS - 1)) ? '0 : wp_r + 1'b1;
  assign issue      = ((state_r == ST_FIR) || (state_r == ST_UPD)) && (cnt_r < CW'(TAPS));
  assign hist_we    = accept;
  assign hist_waddr = wp_inc;
  assign hist_raddr = rp_r;
  assign w_raddr    = cnt_r[AW-1:0];
  assign w_waddr    = (state_r == ST_CLEAR) ? cnt_r[AW-1:0] : a2_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rp_nxt        = rp_r;
    wp_nxt        = wp_r;
    warm_nxt      = warm_r;
    ctl           = '0;
    ctl.mul_sel   = MUL_FIR;
    ctl.d_load    = accept;
    ctl.acc_clr   = accept;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      ST_CLEAR: begin
        ctl.wclr_en = 1'b1;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == CW'(TAPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          wp_nxt = wp_inc;
          if (warm_r < AW'(TAPS - 1)) begin
            warm_nxt = warm_r + 1'b1;
          end else begin
            cnt_nxt   = '0;
            rp_nxt    = wp_inc;
            state_nxt = ST_FIR;
          end
        end
      end
      ST_FIR, ST_UPD: begin
        ctl.mul_sel = (state_r == ST_FIR) ? MUL_FIR : MUL_UPD;
        ctl.acc_en  = v2_r && (state_r == ST_FIR);
        ctl.wupd_en = v2_r && (state_r == ST_UPD);
        cnt_nxt     = cnt_r + 1'b1;
        rp_nxt      = (rp_r == '0) ? AW'(TAPS - 1) : rp_r - 1'b1;
        // the last read passes the RAM read register and the product register before it lands
        if (cnt_r == CW'(TAPS + 1)) begin
          cnt_nxt   = '0;
          state_nxt = (state_r == ST_FIR) ? ST_EST : ST_IDLE;
        end
      end
      ST_EST: begin
        // hold the new error until the previous beat has left
        ctl.est_en = !out_valid_r || out_ready;
        if (ctl.est_en) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_MU;
        end
      end
      ST_MU: begin
        ctl.mul_sel = MUL_STEP;
        state_nxt   = ST_MUE;
      end
      ST_MUE: begin
        ctl.mue_en = 1'b1;
        cnt_nxt    = '0;
        rp_nxt     = wp_r;
        state_nxt  = ST_UPD;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      rp_r        <= '0;
      wp_r        <= '0;
      warm_r      <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rp_r        <= rp_nxt;
      wp_r        <= wp_nxt;
      warm_r      <= warm_nxt;
      v1_r        <= issue;
      v2_r        <= v1_r;
      out_valid_r <= out_valid_nxt;
    end
    a1_r <= cnt_r[AW-1:0];
    a2_r <= a1_r;
  end

endmodule

[hdl/lms_adaptive_noise_canceller.sv]
`timescale 1ns / 1ps
// LMS adaptive noise canceller, top level.
// Depends on lanc_pkg, lanc_if, lanc_ram, lanc_dp and lanc_ctrl.
//
// in_ch carries one beat per sample pair: reference_sample (noise pickup) and
// desired_sample (noisy primary), both signed Q1.15. out_ch carries one
// error_sample beat, the cleaned signal, for every input beat from the TAPS-th
// on; the first TAPS-1 beats only fill the delay line, with in_ch.ready kept
// high. cfg_we/cfg_wdata write the unsigned Q0.16 step size at any
// edge; it resets to 655 and should be changed only while the block is idle.
//
// One multiplier walks all taps twice per sample, the accumulator only in
// the first walk: a filter pass, rounding into the error register (ST_EST,
// which waits while an earlier error beat is still pending) and the mu*error
// product (ST_MU, ST_MUE), then a weight-update pass. A sample that produces
// a result occupies the block from its accept to the next in_ch.ready; the
// error beat is offered before the weight-update pass begins.
//
// Reset (rst_n low, synchronous) clears the delay-line pointers and warm-up
// count; afterwards a sweep over all TAPS addresses zeroes the weight memory with
// in_ch.ready low. If out_ch stalls, the error beat holds in its register;
// the next result waits for it, so no beat is lost.
module lms_adaptive_noise_canceller (
  input  logic                             clk,
  input  logic                             rst_n,
  lanc_in_if.sink                          in_ch,
  lanc_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [lanc_pkg::STEP_W-1:0]      cfg_wdata
);
  import lanc_pkg::*;

  logic [STEP_W-1:0]       step_r;
  ctl_t                    ctl;
  logic                    hist_we;
  logic [AW-1:0]           hist_waddr;
  logic [AW-1:0]           hist_raddr;
  logic [AW-1:0]           w_raddr;
  logic [AW-1:0]           w_waddr;
  logic                    w_we;
  logic signed [SMP_W-1:0] hist_q;
  logic signed [WGT_W-1:0] w_q;
  logic signed [WGT_W-1:0] w_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RESET;
    end else if (cfg_we) begin
      step_r <= cfg_wdata;
    end
  end

  assign w_we = ctl.wupd_en || ctl.wclr_en;

  lanc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .out_ready  (out_ch.ready),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .ctl        (ctl),
    .hist_we    (hist_we),
    .hist_waddr (hist_waddr),
    .hist_raddr (hist_raddr),
    .w_raddr    (w_raddr),
    .w_waddr    (w_waddr)
  );

  lanc_ram #(
    .DEPTH (TAPS),
    .WIDTH (SMP_W)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (in_ch.reference_sample),
    .raddr (hist_raddr),
    .rdata (hist_q)
  );

  lanc_ram #(
    .DEPTH (TAPS),
    .WIDTH (WGT_W)
  ) u_wgt_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_q)
  );

  lanc_dp u_dp (
    .clk            (clk),
    .ctl            (ctl),
    .step_size      (step_r),
    .desired_sample (in_ch.desired_sample),
    .hist_q         (hist_q),
    .w_q            (w_q),
    .error_sample   (out_ch.error_sample),
    .w_wdata        (w_wdata)
  );

  // a sample beat and a weight write never share a cycle
  a_write_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({hist_we, w_we}))
    else $error("delay-line write overlaps weight write");

  // the weight clear sweep keeps the input closed right after reset
  a_clear_closed: assert property (@(posedge clk)
    $rose(rst_n) |-> !in_ch.ready)
    else $error("input open during weight clear");

  // a new error only loads when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.est_en |-> (!out_ch.valid || out_ch.ready))
    else $error("pending error beat overwritten");

endmodule
